FILE: rtl/core/tdfd_pkg.sv
// ----------------------------------------------------------------------------
// tdfd_pkg
// Types and constants shared by the tile delta frame decoder.
// ----------------------------------------------------------------------------
package tdfd_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int TILE_ID_BITS   = 16;
    localparam int BANK_BITS      = 8;
    localparam int DEST_BITS      = 9;
    localparam int ADDR_BITS      = 16;
    localparam int PATTERN_SHIFT  = 5;
    localparam int BANK_SHIFT     = 9;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_BITS-1:0] SKIP_LONG      = 8'd255;
    localparam logic [BYTE_BITS-1:0] LONG_SKIP_STEP = 8'd254;
    localparam logic [BANK_BITS-1:0] BANK_NONE      = 8'hFF;
    localparam logic [ADDR_BITS-1:0] SRC_WINDOW     = 16'h8000;

    // register select, taken from paddr[2]
    localparam logic REG_BANK_BASE = 1'b0;
    localparam logic REG_TILE_BASE = 1'b1;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_COUNT = 2'd1,
        PH_ID_LO = 2'd2,
        PH_ID_HI = 2'd3
    } phase_t;

    typedef struct packed {
        logic                    frame_end;
        logic [TILE_ID_BITS-1:0] tile_id;
        logic [DEST_BITS-1:0]    slot;
    } cmd_t;

endpackage

FILE: rtl/core/tdfd_if.sv
// ----------------------------------------------------------------------------
// tdfd_if
// Valid/ready channels for the frame byte stream and the tile load requests.
// ----------------------------------------------------------------------------
interface tdfd_byte_if;
    import tdfd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface tdfd_result_if;
    import tdfd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BANK_BITS-1:0] rom_bank;
    logic                 bank_changed;
    logic [ADDR_BITS-1:0] source_address;
    logic [DEST_BITS-1:0] dest_tile;
    logic                 frame_end;

    modport source (output valid, output rom_bank, output bank_changed,
                    output source_address, output dest_tile, output frame_end,
                    input ready);
    modport sink (input valid, input rom_bank, input bank_changed,
                  input source_address, input dest_tile, input frame_end,
                  output ready);
endinterface

FILE: rtl/core/tdfd_front.sv
// ----------------------------------------------------------------------------
// tdfd_front
// Stream parser: walks skip/count pairs and tile ids, tracks the cell and
// pushes one command per tile entry or frame end.
// ----------------------------------------------------------------------------
module tdfd_front #(
    parameter int CELL_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    tdfd_byte_if.sink         stream,
    output tdfd_pkg::cmd_t    cmd,
    output logic              cmd_valid,
    input  logic              cmd_ready
);
    import tdfd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [BYTE_BITS-1:0]   skip_reg, skip_next;
    logic [BYTE_BITS-1:0]   run_reg, run_next;
    logic [BYTE_BITS-1:0]   id_lo_reg, id_lo_next;
    logic [CELL_BITS-1:0]   cell_reg, cell_next;
    logic                   accept;
    logic [BYTE_BITS-1:0]   run_dec;
    logic [BYTE_BITS-1:0]   b;

    assign stream.ready = cmd_ready;
    assign accept       = stream.valid && cmd_ready;
    assign b            = stream.data_byte;
    assign run_dec      = run_reg - 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            skip_reg  <= '0;
            run_reg   <= '0;
            id_lo_reg <= '0;
            cell_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            run_reg   <= run_next;
            id_lo_reg <= id_lo_next;
            cell_reg  <= cell_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        skip_next     = skip_reg;
        run_next      = run_reg;
        id_lo_next    = id_lo_reg;
        cell_next     = cell_reg;
        cmd_valid     = 1'b0;
        cmd.frame_end = 1'b0;
        cmd.tile_id   = {b, id_lo_reg};
        cmd.slot      = cell_reg[DEST_BITS-1:0];
        if (accept)
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    skip_next  = b;
                    phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    if (skip_reg == SKIP_LONG && b == '0)
                    begin
                        cell_next  = cell_reg + {{(CELL_BITS-BYTE_BITS){1'b0}}, LONG_SKIP_STEP};
                        phase_next = PH_SKIP;
                    end
                    else if (skip_reg == '0 && b == '0)
                    begin
                        cmd_valid     = 1'b1;
                        cmd.frame_end = 1'b1;
                        phase_next    = PH_SKIP;
                        skip_next     = '0;
                        run_next      = '0;
                        id_lo_next    = '0;
                        cell_next     = '0;
                    end
                    else
                    begin
                        cell_next  = cell_reg + {{(CELL_BITS-BYTE_BITS){1'b0}}, skip_reg};
                        run_next   = b;
                        phase_next = (b == '0) ? PH_SKIP : PH_ID_LO;
                    end
                end
                PH_ID_LO:
                begin
                    id_lo_next = b;
                    phase_next = PH_ID_HI;
                end
                PH_ID_HI:
                begin
                    cmd_valid  = 1'b1;
                    cell_next  = cell_reg + {{(CELL_BITS-1){1'b0}}, 1'b1};
                    run_next   = run_dec;
                    phase_next = (run_dec == '0) ? PH_SKIP : PH_ID_LO;
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/tdfd_queue.sv
// ----------------------------------------------------------------------------
// tdfd_queue
// Two-entry command queue between the parser and the request builder.
// ----------------------------------------------------------------------------
module tdfd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  tdfd_pkg::cmd_t    push_cmd,
    input  logic              push_valid,
    output logic              push_ready,
    output tdfd_pkg::cmd_t    pop_cmd,
    output logic              pop_valid,
    input  logic              pop_ready
);
    import tdfd_pkg::*;

    cmd_t                      mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic                      do_push;
    logic                      do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

FILE: rtl/core/tdfd_back.sv
// ----------------------------------------------------------------------------
// tdfd_back
// Request builder: turns commands into bank, pattern address and VRAM tile,
// tracks the last bank of the frame and holds the result register.
// ----------------------------------------------------------------------------
module tdfd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tdfd_pkg::BANK_BITS-1:0] bank_base,
    input  logic [tdfd_pkg::DEST_BITS-1:0] tile_base,
    input  tdfd_pkg::cmd_t                cmd,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    tdfd_result_if.source                 result
);
    import tdfd_pkg::*;

    logic                 valid_reg, valid_next;
    logic [BANK_BITS-1:0] last_bank_reg, last_bank_next;
    logic [BANK_BITS-1:0] bank_reg, bank_next;
    logic                 changed_reg, changed_next;
    logic [ADDR_BITS-1:0] src_reg, src_next;
    logic [DEST_BITS-1:0] dest_reg, dest_next;
    logic                 end_reg, end_next;
    logic                 pop;
    logic [BANK_BITS-1:0] bank;

    assign cmd_ready = !valid_reg || result.ready;
    assign pop       = cmd_valid && cmd_ready;
    assign bank      = bank_base
                     + {{(BANK_BITS-(TILE_ID_BITS-BANK_SHIFT)){1'b0}},
                        cmd.tile_id[TILE_ID_BITS-1:BANK_SHIFT]};

    always_comb
    begin
        valid_next     = valid_reg && !result.ready;
        last_bank_next = last_bank_reg;
        bank_next      = bank_reg;
        changed_next   = changed_reg;
        src_next       = src_reg;
        dest_next      = dest_reg;
        end_next       = end_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            if (cmd.frame_end)
            begin
                last_bank_next = BANK_NONE;
                bank_next      = '0;
                changed_next   = 1'b0;
                src_next       = '0;
                dest_next      = '0;
                end_next       = 1'b1;
            end
            else
            begin
                last_bank_next = bank;
                bank_next      = bank;
                changed_next   = (bank != last_bank_reg);
                src_next       = SRC_WINDOW
                               + {{(ADDR_BITS-BANK_SHIFT-PATTERN_SHIFT){1'b0}},
                                  cmd.tile_id[BANK_SHIFT-1:0], {PATTERN_SHIFT{1'b0}}};
                dest_next      = tile_base + cmd.slot;
                end_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            last_bank_reg <= BANK_NONE;
        end
        else
        begin
            valid_reg     <= valid_next;
            last_bank_reg <= last_bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg    <= bank_next;
        changed_reg <= changed_next;
        src_reg     <= src_next;
        dest_reg    <= dest_next;
        end_reg     <= end_next;
    end

    assign result.valid          = valid_reg;
    assign result.rom_bank       = bank_reg;
    assign result.bank_changed   = changed_reg;
    assign result.source_address = src_reg;
    assign result.dest_tile      = dest_reg;
    assign result.frame_end      = end_reg;

    a_end_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && end_reg) |-> (bank_reg == '0 && !changed_reg
                                    && src_reg == '0 && dest_reg == '0))
        else $error("frame end request carries nonzero fields");

    a_end_clears_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.frame_end) |=> (last_bank_reg == BANK_NONE))
        else $error("last bank not cleared at frame end");

    a_entry_tracks_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !cmd.frame_end) |=> (valid_reg && last_bank_reg == bank_reg))
        else $error("last bank does not follow issued request");

endmodule

FILE: rtl/core/tile_delta_frame_decoder.sv
// ----------------------------------------------------------------------------
// tile_delta_frame_decoder
// Delta-coded frame decoder: byte stream in, tile load requests out.
// ----------------------------------------------------------------------------
// Accepts one frame byte per clock while the command queue has room and issues
// one tile load request per tile entry plus one frame-end request per (0,0)
// pair. A request passes through the two-entry command queue and then the
// result register. Input ready drops only while the command queue is full, so
// with the result side taking every cycle the sustained rate is one byte per
// clock. bank_base and tile_base are written over the APB port at 0x0 and 0x4
// and must only change while idle.
// ----------------------------------------------------------------------------
module tile_delta_frame_decoder #(
    parameter int CELL_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tdfd_byte_if.sink                         stream,
    tdfd_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tdfd_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [tdfd_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [tdfd_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import tdfd_pkg::*;

    logic [BANK_BITS-1:0] bank_base_reg;
    logic [DEST_BITS-1:0] tile_base_reg;
    logic                 cfg_write;
    logic                 reg_sel;
    cmd_t                 front_cmd;
    logic                 front_valid;
    logic                 front_ready;
    cmd_t                 back_cmd;
    logic                 back_valid;
    logic                 back_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_base_reg <= '0;
            tile_base_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_BANK_BASE: bank_base_reg <= pwdata[BANK_BITS-1:0];
                REG_TILE_BASE: tile_base_reg <= pwdata[DEST_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BANK_BASE: prdata = {{(CFG_DATA_BITS-BANK_BITS){1'b0}}, bank_base_reg};
            REG_TILE_BASE: prdata = {{(CFG_DATA_BITS-DEST_BITS){1'b0}}, tile_base_reg};
            default:       prdata = '0;
        endcase
    end

    tdfd_front #(
        .CELL_BITS (CELL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    tdfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (back_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    tdfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .bank_base (bank_base_reg),
        .tile_base (tile_base_reg),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .result    (result)
    );

endmodule
